// ===== rtl/core/dvdm_pkg.sv =====
// Package with the payload types, the layer table and the constants of the depth velocity model.
package dvdm_pkg;

    localparam int LAYERS_DEF  = 9;
    localparam int TABLE_SLOTS = 16;

    localparam logic signed [27:0] LAYER_DEPTH_CM [TABLE_SLOTS] = '{
        28'sd100000, 28'sd500000, 28'sd600000, 28'sd1000000, 28'sd1550000,
        28'sd1650000, 28'sd2200000, 28'sd3100000, 28'sd3300000,
        28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0
    };

    localparam logic [22:0] LAYER_VP_MMPS [TABLE_SLOTS] = '{
        23'd5000000, 23'd5500000, 23'd6300000, 23'd6300000, 23'd6400000,
        23'd6700000, 23'd6750000, 23'd6800000, 23'd7800000,
        23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0
    };

    localparam logic [21:0] RHO_BASE     = 22'd1865000;
    localparam logic [10:0] RHO_NUM      = 11'd1579;
    localparam logic [38:0] RHO_LO_Q     = 39'd2060000 << 16;
    localparam logic [38:0] RHO_HI_Q     = 39'd2500000 << 16;
    localparam logic [14:0] NU_MAX_Q     = 15'd26214;
    localparam logic [14:0] NU_MIN_Q     = 15'd16384;
    localparam logic [15:0] HALF_Q       = 16'd32768;
    localparam logic [16:0] ONE_Q        = 17'd65536;

    // Division by 10000 is (x >> 4) times this reciprocal of 625, shifted right by 56.
    localparam logic [46:0] RHO_RECIP    = 47'd115292150460685;
    // Division by 8800000 is (x >> 8) times this reciprocal of 34375, shifted right by 45.
    localparam logic [29:0] NU_RECIP     = 30'd1023545370;

    localparam logic REG_IDX_MODEL_ID = 1'b0;

    typedef struct packed {
        logic signed [27:0] depth_cm;
        logic               depth_mode_ok;
        logic               point_unset;
        logic               last_point;
    } query_t;

    typedef struct packed {
        logic [22:0] vp_mmps;
        logic [22:0] vs_mmps;
        logic [21:0] rho_gpm3;
        logic [7:0]  model_tag;
        logic        written;
        logic        status;
        logic        result_last;
    } result_t;

endpackage

// ===== rtl/core/dvdm_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, with side data carried along.
module dvdm_div #(
    parameter int NW = 45,
    parameter int DW = 29,
    parameter int QW = 16,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  rem_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic          vld_reg  [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int K = QW - 1 - s;
        logic [W-1:0]  rem_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_in_s;
        logic          vld_in;
        logic [W-1:0]  trial;
        logic [W-1:0]  rem_next;
        logic [QW-1:0] quo_next;

        if (s == 0) begin : g_first
            assign rem_in    = W'(num);
            assign quo_in    = '0;
            assign den_in    = den;
            assign side_in_s = side_in;
            assign vld_in    = in_valid;
        end else begin : g_rest
            assign rem_in    = rem_reg[s-1];
            assign quo_in    = quo_reg[s-1];
            assign den_in    = den_reg[s-1];
            assign side_in_s = side_reg[s-1];
            assign vld_in    = vld_reg[s-1];
        end

        assign trial = W'(den_in) << K;

        always_comb
        begin
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= trial)
            begin
                rem_next    = rem_in - trial;
                quo_next[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                den_reg[s]  <= den_in;
                side_reg[s] <= side_in_s;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

// ===== rtl/core/depth_velocity_density_model.sv =====
// Top level of the layered depth velocity and density model with its register port.
// Throughput is one point per cycle while no result stalls; the two bit-per-stage dividers
// for the layer ratio and the speed ratio and the sixteen-stage square root set the depth.
// The whole pipeline holds while a result stalls, so nothing is lost or repeated.
// Reset clears all valid bits and sets model_id to zero; no clearing pass is needed.
module depth_velocity_density_model
    import dvdm_pkg::*;
#(
    parameter int LAYERS = LAYERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        query_valid,
    output logic        query_ready,
    input  query_t      query,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    localparam int N = (LAYERS > TABLE_SLOTS) ? TABLE_SLOTS : ((LAYERS < 1) ? 1 : LAYERS);

    typedef struct packed {
        logic ok;
        logic unset;
        logic last;
    } flags_t;

    typedef struct packed {
        logic [22:0]        vbase;
        logic signed [23:0] dv;
        flags_t             flags;
    } seg_t;

    typedef struct packed {
        logic [38:0] vp;
        flags_t      flags;
    } vp_item_t;

    typedef struct packed {
        logic [38:0] vp;
        logic [21:0] rho;
        logic        nu_lo;
        logic        nu_hi;
        flags_t      flags;
    } nu_item_t;

    typedef struct packed {
        logic [38:0] vp;
        logic [21:0] rho;
        flags_t      flags;
    } q_item_t;

    logic       en;
    logic [7:0] model_id_reg;

    assign en          = !result_valid || result_ready;
    assign query_ready = en;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_IDX_MODEL_ID) ? {24'd0, model_id_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_id_reg <= 8'd0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_IDX_MODEL_ID)
        begin
            model_id_reg <= pwdata[7:0];
        end
    end

    // Segment selection.
    seg_t        s1_next, s1_reg;
    logic [28:0] off_next, off_reg, span_next, span_reg;
    logic        s1_vld_reg;

    always_comb
    begin
        logic               found;
        int                 kp;
        logic signed [28:0] span_s;
        logic signed [28:0] off_s;
        found             = 1'b0;
        kp                = 0;
        span_s            = '0;
        off_s             = '0;
        s1_next.vbase     = LAYER_VP_MMPS[N-1];
        s1_next.dv        = '0;
        s1_next.flags.ok    = query.depth_mode_ok;
        s1_next.flags.unset = query.point_unset;
        s1_next.flags.last  = query.last_point;
        off_next          = '0;
        span_next         = 29'd1;
        for (int k = 0; k < N; k++)
        begin
            if (!found && LAYER_DEPTH_CM[k] > query.depth_cm)
            begin
                found = 1'b1;
                kp    = (k == 0) ? 0 : k - 1;
                s1_next.vbase = LAYER_VP_MMPS[kp];
                if (k != 0)
                begin
                    span_s = 29'(LAYER_DEPTH_CM[k]) - 29'(LAYER_DEPTH_CM[kp]);
                    off_s  = 29'(query.depth_cm) - 29'(LAYER_DEPTH_CM[kp]);
                    s1_next.dv = $signed({1'b0, LAYER_VP_MMPS[k]})
                               - $signed({1'b0, LAYER_VP_MMPS[kp]});
                    if (span_s > 0 && off_s >= 0)
                    begin
                        off_next  = off_s;
                        span_next = span_s;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= query_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= s1_next;
            off_reg  <= off_next;
            span_reg <= span_next;
        end
    end

    // Interpolation ratio.
    logic              d1_vld;
    logic [15:0]       ratio;
    logic [$bits(seg_t)-1:0] d1_side;
    seg_t              d1_seg;

    dvdm_div #(.NW(45), .DW(29), .QW(16), .SW($bits(seg_t))) u_div_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s1_vld_reg),
        .num      ({off_reg, 16'd0}),
        .den      (span_reg),
        .side_in  (s1_reg),
        .out_valid(d1_vld),
        .quo      (ratio),
        .side_out (d1_side)
    );

    assign d1_seg = seg_t'(d1_side);

    // P speed.
    vp_item_t           vp_next, vp_reg;
    logic               vp_vld_reg;
    logic signed [40:0] vp_sum;

    always_comb
    begin
        vp_sum = $signed({2'b00, d1_seg.vbase, 16'd0}) + d1_seg.dv * $signed({1'b0, ratio});
        vp_next.vp    = vp_sum[40] ? 39'd0 : vp_sum[38:0];
        vp_next.flags = d1_seg.flags;
    end

    // Density product.
    vp_item_t    pr_reg;
    logic [49:0] prod_reg;
    logic        pr_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_vld_reg <= 1'b0;
            pr_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_vld_reg <= d1_vld;
            pr_vld_reg <= vp_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vp_reg   <= vp_next;
            pr_reg   <= vp_reg;
            prod_reg <= vp_reg.vp * RHO_NUM;
        end
    end

    // Density quotient by reciprocal multiplication over three stages.
    vp_item_t    r1_reg, r2_reg, r3_reg;
    logic        r1_vld_reg, r2_vld_reg, r3_vld_reg;
    logic [45:0] rx;
    logic [45:0] rhh_reg, rhh2_reg;
    logic [46:0] rhl_reg;
    logic [45:0] rlh_reg;
    logic [46:0] rll_reg, rll2_reg;
    logic [47:0] rmid_reg;
    logic [92:0] rtot;
    logic [36:0] rho_frac_reg;

    assign rx   = prod_reg[49:4];
    assign rtot = {rhh2_reg, 47'd0} + {22'd0, rmid_reg, 23'd0} + {46'd0, rll2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
            r3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_vld_reg <= pr_vld_reg;
            r2_vld_reg <= r1_vld_reg;
            r3_vld_reg <= r2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg       <= pr_reg;
            rhh_reg      <= rx[45:23] * RHO_RECIP[46:24];
            rhl_reg      <= rx[45:23] * RHO_RECIP[23:0];
            rlh_reg      <= rx[22:0] * RHO_RECIP[46:24];
            rll_reg      <= rx[22:0] * RHO_RECIP[23:0];
            r2_reg       <= r1_reg;
            rhh2_reg     <= rhh_reg;
            rmid_reg     <= {1'b0, rhl_reg} + {1'b0, rlh_reg, 1'b0};
            rll2_reg     <= rll_reg;
            r3_reg       <= r2_reg;
            rho_frac_reg <= rtot[92:56];
        end
    end

    // Poisson ratio set-up.
    nu_item_t    nu_next, nu_reg;
    logic [36:0] nnum_next, nnum_reg;
    logic        nu_vld_reg;
    logic [38:0] rho_q;
    logic [38:0] rho_diff;

    always_comb
    begin
        rho_q    = {RHO_BASE, 16'd0} + {2'b00, rho_frac_reg};
        rho_diff = rho_q - RHO_LO_Q;
        nu_next.vp    = r3_reg.vp;
        nu_next.rho   = rho_q[37:16];
        nu_next.nu_lo = rho_q < RHO_LO_Q;
        nu_next.nu_hi = rho_q > RHO_HI_Q;
        nu_next.flags = r3_reg.flags;
        nnum_next     = '0;
        if (!nu_next.nu_lo && !nu_next.nu_hi)
        begin
            nnum_next = rho_diff[36:0] + {rho_diff[35:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nu_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            nu_vld_reg <= r3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nu_reg   <= nu_next;
            nnum_reg <= nnum_next;
        end
    end

    // Poisson ratio step by reciprocal multiplication.
    nu_item_t    n1_reg;
    logic [13:0] nu_step_reg;
    logic [58:0] nprod;
    logic        n1_vld_reg;

    assign nprod = nnum_reg[36:8] * NU_RECIP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            n1_vld_reg <= nu_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg      <= nu_reg;
            nu_step_reg <= nprod[58:45];
        end
    end

    // Speed ratio set-up.
    q_item_t     q_next, q_reg;
    logic [46:0] qnum_next, qnum_reg;
    logic [16:0] qden_next, qden_reg;
    logic        q_vld_reg;
    logic [14:0] nu;

    always_comb
    begin
        priority if (n1_reg.nu_lo)
        begin
            nu = NU_MAX_Q;
        end
        else if (n1_reg.nu_hi)
        begin
            nu = NU_MIN_Q;
        end
        else
        begin
            nu = NU_MAX_Q - {1'b0, nu_step_reg};
        end
        qnum_next    = {15'(HALF_Q - {1'b0, nu}), 32'd0};
        qden_next    = ONE_Q - {2'b00, nu};
        q_next.vp    = n1_reg.vp;
        q_next.rho   = n1_reg.rho;
        q_next.flags = n1_reg.flags;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            q_vld_reg <= n1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg    <= q_next;
            qnum_reg <= qnum_next;
            qden_reg <= qden_next;
        end
    end

    logic                       d4_vld;
    logic [31:0]                q_val;
    logic [$bits(q_item_t)-1:0] d4_side;

    dvdm_div #(.NW(47), .DW(17), .QW(32), .SW($bits(q_item_t))) u_div_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (q_vld_reg),
        .num      (qnum_reg),
        .den      (qden_reg),
        .side_in  (q_reg),
        .out_valid(d4_vld),
        .quo      (q_val),
        .side_out (d4_side)
    );

    // Square root, one result bit per stage.
    localparam int SQ_STAGES = 16;

    logic [31:0] sq_x_reg    [SQ_STAGES];
    logic [31:0] sq_r_reg    [SQ_STAGES];
    q_item_t     sq_item_reg [SQ_STAGES];
    logic        sq_vld_reg  [SQ_STAGES];

    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
        localparam logic [31:0] B = 32'd1 << (30 - 2 * j);
        logic [31:0] x_in, r_in, x_next, r_next;
        q_item_t     item_in;
        logic        vld_in;
        logic [32:0] trial;

        if (j == 0) begin : g_first
            assign x_in    = q_val;
            assign r_in    = '0;
            assign item_in = q_item_t'(d4_side);
            assign vld_in  = d4_vld;
        end else begin : g_rest
            assign x_in    = sq_x_reg[j-1];
            assign r_in    = sq_r_reg[j-1];
            assign item_in = sq_item_reg[j-1];
            assign vld_in  = sq_vld_reg[j-1];
        end

        assign trial = {1'b0, r_in} + {1'b0, B};

        always_comb
        begin
            x_next = x_in;
            r_next = r_in >> 1;
            if ({1'b0, x_in} >= trial)
            begin
                x_next = x_in - trial[31:0];
                r_next = (r_in >> 1) + B;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                sq_vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_x_reg[j]    <= x_next;
                sq_r_reg[j]    <= r_next;
                sq_item_reg[j] <= item_in;
            end
        end
    end

    // S speed and result.
    q_item_t     last_item;
    logic [54:0] vs_q;
    logic        wr;
    result_t     result_next, result_reg;
    logic        result_valid_reg;

    assign last_item = sq_item_reg[SQ_STAGES-1];

    always_comb
    begin
        vs_q = last_item.vp * sq_r_reg[SQ_STAGES-1][15:0];
        wr   = last_item.flags.ok && last_item.flags.unset;
        result_next.vp_mmps     = wr ? last_item.vp[38:16] : 23'd0;
        result_next.vs_mmps     = wr ? vs_q[54:32] : 23'd0;
        result_next.rho_gpm3    = wr ? last_item.rho : 22'd0;
        result_next.model_tag   = wr ? model_id_reg : 8'd0;
        result_next.written     = wr;
        result_next.status      = !last_item.flags.ok;
        result_next.result_last = last_item.flags.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= sq_vld_reg[SQ_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_written_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.written && result.status))
        else $error("written point carries an error status");

    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.written |-> result.vp_mmps == 23'd0 &&
        result.vs_mmps == 23'd0 && result.rho_gpm3 == 22'd0 && result.model_tag == 8'd0)
        else $error("unwritten point has nonzero properties");

    a_vs_below_vp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.written |-> result.vs_mmps <= result.vp_mmps)
        else $error("S speed exceeds P speed");

    a_rho_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.written |-> result.rho_gpm3 >= RHO_BASE)
        else $error("density below its base value");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !query_ready |=> result_valid && $stable(sq_vld_reg[SQ_STAGES-1]))
        else $error("pipeline moved during a stall");

endmodule
